>>> design/dtcst_pkg.sv
package dtcst_pkg;

  localparam int unsigned ENTRIES_DEF = 32;
  localparam int unsigned DEFAULT_CONFIRM_DEF = 3;
  localparam int unsigned DEFAULT_AGING_DEF = 40;

  typedef enum logic [3:0] {
    CMD_REGISTER   = 4'd0,
    CMD_FAIL_CODE  = 4'd1,
    CMD_PASS_CODE  = 4'd2,
    CMD_FAIL_KEY   = 4'd3,
    CMD_PASS_KEY   = 4'd4,
    CMD_CLEAR      = 4'd5,
    CMD_CLEAR_ALL  = 4'd6,
    CMD_RST_CNT    = 4'd7,
    CMD_READ_CODE  = 4'd8,
    CMD_READ_KEY   = 4'd9,
    CMD_CYCLE_END  = 4'd10
  } cmd_e;

  typedef enum logic [1:0] {
    RES_OK        = 2'd0,
    RES_NOT_FOUND = 2'd1,
    RES_EXISTS    = 2'd2,
    RES_FULL      = 2'd3
  } res_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_CAPACITY = 2'd0,
    REG_CONFIRM  = 2'd1,
    REG_AGING    = 2'd2
  } reg_e;

  localparam logic [7:0] ST_FAIL     = 8'h01;
  localparam logic [7:0] ST_FAIL_CYC = 8'h02;
  localparam logic [7:0] ST_PEND     = 8'h04;
  localparam logic [7:0] ST_CONF     = 8'h08;
  localparam logic [7:0] ST_NC_CLR   = 8'h10;
  localparam logic [7:0] ST_FAIL_CLR = 8'h20;
  localparam logic [7:0] ST_NC_CYC   = 8'h40;

  // one record's contents
  typedef struct packed {
    logic [23:0] code;
    logic [23:0] key;
    logic [2:0]  sev;
    logic [7:0]  status;
    logic        active;
    logic        latch;
    logic [7:0]  fcyc;
    logic [15:0] aging;
    logic [31:0] occ;
    logic [31:0] act;
    logic [31:0] clr;
  } rec_t;

  // command word walking down the chain
  typedef struct packed {
    logic        valid;
    logic [3:0]  cmd;
    logic        found;
    logic        written;
    rec_t        data;
  } tok_t;

  function automatic logic [31:0] sat32(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

>>> design/dtcst_cell.sv
module dtcst_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CW-1:0]     count_i,
  input  logic              room_i,
  input  logic [7:0]        conf_i,
  input  logic [15:0]       age_i,
  input  dtcst_pkg::tok_t   tok_i,
  output dtcst_pkg::tok_t   tok_o
);

  dtcst_pkg::rec_t rec_q, rec_d;
  dtcst_pkg::tok_t tok_q, tok_d;

  logic used, mcode, mkey, hit;

  function automatic dtcst_pkg::rec_t clear_rec(dtcst_pkg::rec_t r);
    dtcst_pkg::rec_t n;
    n = r;
    if (r.active || r.status != 8'd0) begin
      n.active = 1'b0;
      n.clr = dtcst_pkg::sat32(r.clr);
    end
    n.status = 8'd0;
    n.latch = 1'b0;
    n.fcyc = 8'd0;
    n.aging = 16'd0;
    return n;
  endfunction

  always_comb begin
    used  = CW'(IDX) < count_i;
    mcode = used && (rec_q.code == tok_i.data.code);
    mkey  = used && (rec_q.key == tok_i.data.key);
    rec_d = rec_q;
    tok_d = tok_i;
    hit   = 1'b0;
    if (tok_i.valid) begin
      unique case (tok_i.cmd)
        dtcst_pkg::CMD_REGISTER: begin
          if (mcode || mkey) tok_d.found = 1'b1;
          // first free slot; earlier records were already checked
          if (CW'(IDX) == count_i && !tok_i.found && room_i) begin
            rec_d = '0;
            rec_d.code = tok_i.data.code;
            rec_d.key  = tok_i.data.key;
            rec_d.sev  = tok_i.data.sev;
            tok_d.written = 1'b1;
          end
        end
        dtcst_pkg::CMD_FAIL_CODE, dtcst_pkg::CMD_PASS_CODE, dtcst_pkg::CMD_CLEAR,
        dtcst_pkg::CMD_RST_CNT, dtcst_pkg::CMD_READ_CODE:
          hit = mcode && !tok_i.found;
        dtcst_pkg::CMD_FAIL_KEY, dtcst_pkg::CMD_PASS_KEY, dtcst_pkg::CMD_READ_KEY:
          hit = mkey && !tok_i.found;
        dtcst_pkg::CMD_CLEAR_ALL:
          if (used) rec_d = clear_rec(rec_q);
        dtcst_pkg::CMD_CYCLE_END: begin
          if (used) begin
            if (rec_q.latch) begin
              rec_d.aging = 16'd0;
              if (rec_q.fcyc != 8'hFF) rec_d.fcyc = rec_q.fcyc + 8'd1;
              if (rec_d.fcyc >= conf_i) rec_d.status = rec_q.status | dtcst_pkg::ST_CONF;
              rec_d.latch = 1'b0;
              rec_d.status = (rec_d.status & ~dtcst_pkg::ST_FAIL_CYC) | dtcst_pkg::ST_NC_CYC;
            end else if (!rec_q.active) begin
              rec_d.fcyc = 8'd0;
              rec_d.status = rec_q.status & ~dtcst_pkg::ST_PEND;
              if ((rec_q.status & dtcst_pkg::ST_CONF) != 8'd0 && rec_q.aging != 16'hFFFF)
                rec_d.aging = rec_q.aging + 16'd1;
              if ((rec_q.status & dtcst_pkg::ST_CONF) != 8'd0 && rec_d.aging >= age_i) begin
                // healed
                rec_d.status = 8'd0;
                rec_d.aging  = 16'd0;
              end else begin
                rec_d.status = (rec_d.status & ~dtcst_pkg::ST_FAIL_CYC)
                               | dtcst_pkg::ST_NC_CYC;
              end
            end else begin
              rec_d.fcyc = 8'd0;
              rec_d.latch = 1'b0;
              rec_d.status = (rec_q.status & ~dtcst_pkg::ST_FAIL_CYC) | dtcst_pkg::ST_NC_CYC;
            end
          end
        end
        default: ;
      endcase
      if (hit) begin
        tok_d.found = 1'b1;
        unique case (tok_i.cmd)
          dtcst_pkg::CMD_FAIL_CODE, dtcst_pkg::CMD_FAIL_KEY: begin
            if (!rec_q.active) begin
              rec_d.occ = dtcst_pkg::sat32(rec_q.occ);
              rec_d.act = dtcst_pkg::sat32(rec_q.act);
            end
            rec_d.active = 1'b1;
            rec_d.latch  = 1'b1;
            rec_d.status = (rec_q.status | dtcst_pkg::ST_FAIL | dtcst_pkg::ST_FAIL_CYC
                            | dtcst_pkg::ST_PEND | dtcst_pkg::ST_FAIL_CLR)
                           & ~(dtcst_pkg::ST_NC_CLR | dtcst_pkg::ST_NC_CYC);
          end
          dtcst_pkg::CMD_PASS_CODE, dtcst_pkg::CMD_PASS_KEY: begin
            rec_d.active = 1'b0;
            rec_d.status = rec_q.status
                           & ~(dtcst_pkg::ST_FAIL | dtcst_pkg::ST_NC_CLR | dtcst_pkg::ST_NC_CYC);
          end
          dtcst_pkg::CMD_CLEAR: rec_d = clear_rec(rec_q);
          dtcst_pkg::CMD_RST_CNT: begin
            rec_d.occ = 32'd0;
            rec_d.act = 32'd0;
            rec_d.clr = 32'd0;
            rec_d.fcyc = 8'd0;
            rec_d.aging = 16'd0;
          end
          default: tok_d.data = rec_q;  // read
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

>>> design/dtc_status_table.sv
// Channel | Direction | Handshake              | Word
// cmd     | in        | start / busy           | command_i, dtc_code_i, fault_key_i, severity_i
// cfg     | in        | cfg_valid_i/cfg_ready_o| cfg_addr_i, cfg_data_i
// result  | out       | done_o (one cycle)     | result_code_o ... clears_out_o
// A command walks the row of record cells, one cell per clock; done_o is high while
// the command is held in the token register of the last cell.
// busy stays high from the accepting edge through the done cycle, so the next command
// is not taken before the last one has left the row.
// Reset clears the walking command and the record count; record contents have no
// reset. The result cannot be stalled; cfg_ready_o is always high.
module dtc_status_table #(
  parameter int unsigned ENTRIES         = dtcst_pkg::ENTRIES_DEF,
  parameter int unsigned DEFAULT_CONFIRM = dtcst_pkg::DEFAULT_CONFIRM_DEF,
  parameter int unsigned DEFAULT_AGING   = dtcst_pkg::DEFAULT_AGING_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  command_i,
  input  logic [23:0] dtc_code_i,
  input  logic [23:0] fault_key_i,
  input  logic [2:0]  severity_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_addr_i,
  input  logic [15:0] cfg_data_i,
  output logic        done_o,
  output logic [1:0]  result_code_o,
  output logic [23:0] code_out_o,
  output logic [23:0] key_out_o,
  output logic [2:0]  severity_out_o,
  output logic [7:0]  status_byte_o,
  output logic        active_out_o,
  output logic        failed_latch_out_o,
  output logic [7:0]  failed_cycles_out_o,
  output logic [15:0] aging_out_o,
  output logic [31:0] occurrences_out_o,
  output logic [31:0] activations_out_o,
  output logic [31:0] clears_out_o
);

  localparam int unsigned CW = $clog2(ENTRIES + 1);

  logic [5:0]  cap_q;
  logic [7:0]  conf_q;
  logic [15:0] age_q;
  logic [CW-1:0] count_q;
  logic        busy_q;
  logic [7:0]  conf_eff;
  logic [15:0] age_eff;
  logic        room;
  dtcst_pkg::tok_t tok [ENTRIES+1];
  dtcst_pkg::tok_t fin;
  logic        accept, is_reg, is_look;

  assign accept = start && !busy_q;
  assign busy = busy_q;
  assign cfg_ready_o = 1'b1;
  assign conf_eff = (conf_q == 8'd0) ? 8'(DEFAULT_CONFIRM) : conf_q;
  assign age_eff  = (age_q == 16'd0) ? 16'(DEFAULT_AGING) : age_q;
  // capacity above the row size is clipped to it
  assign room = (32'(count_q) < 32'(cap_q)) && (32'(count_q) < ENTRIES);

  always_comb begin
    tok[0] = '0;
    tok[0].valid = accept;
    tok[0].cmd = command_i;
    tok[0].data.code = dtc_code_i;
    tok[0].data.key = fault_key_i;
    tok[0].data.sev = severity_i;
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    dtcst_cell #(.IDX(g), .CW(CW)) u_cell (
      .clk_i, .rst_ni,
      .count_i(count_q), .room_i(room), .conf_i(conf_eff), .age_i(age_eff),
      .tok_i(tok[g]), .tok_o(tok[g+1])
    );
  end

  assign fin = tok[ENTRIES];
  assign is_reg = fin.cmd == dtcst_pkg::CMD_REGISTER;
  assign is_look = (fin.cmd >= dtcst_pkg::CMD_FAIL_CODE && fin.cmd <= dtcst_pkg::CMD_CLEAR)
                   || (fin.cmd >= dtcst_pkg::CMD_RST_CNT && fin.cmd <= dtcst_pkg::CMD_READ_KEY);
  assign done_o = fin.valid;

  always_comb begin
    priority if (is_reg) begin
      result_code_o = fin.found ? dtcst_pkg::RES_EXISTS
                    : (fin.written ? dtcst_pkg::RES_OK : dtcst_pkg::RES_FULL);
    end else if (is_look) begin
      result_code_o = fin.found ? dtcst_pkg::RES_OK : dtcst_pkg::RES_NOT_FOUND;
    end else begin
      result_code_o = dtcst_pkg::RES_OK;
    end
  end

  // data fields carry the record only after a read hit
  logic rd;
  dtcst_pkg::rec_t od;
  assign rd = fin.found && (fin.cmd == dtcst_pkg::CMD_READ_CODE
                            || fin.cmd == dtcst_pkg::CMD_READ_KEY);
  assign od = rd ? fin.data : '0;
  assign code_out_o = od.code;
  assign key_out_o = od.key;
  assign severity_out_o = od.sev;
  assign status_byte_o = od.status;
  assign active_out_o = od.active;
  assign failed_latch_out_o = od.latch;
  assign failed_cycles_out_o = od.fcyc;
  assign aging_out_o = od.aging;
  assign occurrences_out_o = od.occ;
  assign activations_out_o = od.act;
  assign clears_out_o = od.clr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= 6'd32;
      conf_q <= 8'd0;
      age_q <= 16'd0;
      count_q <= '0;
      busy_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_addr_i)
          dtcst_pkg::REG_CAPACITY: cap_q <= cfg_data_i[5:0];
          dtcst_pkg::REG_CONFIRM:  conf_q <= cfg_data_i[7:0];
          dtcst_pkg::REG_AGING:    age_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) busy_q <= 1'b1;
      else if (fin.valid) busy_q <= 1'b0;
      if (fin.valid && is_reg && fin.written) count_q <= count_q + CW'(1);
    end
  end

endmodule

>>> design/dtcst_checker.sv
module dtcst_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       done_o,
  input logic [1:0] result_code_o,
  input logic [7:0] status_byte_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("busy not raised after accept");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result while idle");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy) else $error("busy held after result");

  a_read_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_byte_o != 8'd0 |-> result_code_o == dtcst_pkg::RES_OK)
    else $error("read data on failed command");

endmodule

bind dtc_status_table dtcst_checker u_dtcst_checker (
  .clk_i, .rst_ni, .start, .busy, .done_o, .result_code_o, .status_byte_o
);
